[rtl/ksr_pkg.sv]
`timescale 1ns / 1ps
package ksr_pkg;

    localparam int KEY_W          = 64;
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_PAYLOAD_W  = 32;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_POST
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic scan;
        logic shift;
    } t_cmd;

endpackage

[rtl/ksr_cell.sv]
`timescale 1ns / 1ps
module ksr_cell #(
    parameter int PAYLOAD_WIDTH = ksr_pkg::DEF_PAYLOAD_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ksr_pkg::t_cmd              i_cmd,
    input  logic [ksr_pkg::KEY_W-1:0]  i_new_key,
    input  logic [PAYLOAD_WIDTH-1:0]   i_new_payload,
    input  logic [ksr_pkg::KEY_W-1:0]  i_skey,
    input  logic                       i_tok,
    input  logic                       i_below_valid,
    input  logic                       i_above_valid,
    input  logic [ksr_pkg::KEY_W-1:0]  i_above_key,
    input  logic [PAYLOAD_WIDTH-1:0]   i_above_payload,
    output logic                       o_valid,
    output logic [ksr_pkg::KEY_W-1:0]  o_key,
    output logic [PAYLOAD_WIDTH-1:0]   o_payload,
    output logic                       o_tok,
    output logic                       o_hit,
    output logic                       o_sel,
    output logic                       o_last,
    output logic                       o_miss
);
    import ksr_pkg::*;

    logic                     r_valid;
    logic                     r_tok;
    logic [KEY_W-1:0]         r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic                     w_hit;
    logic                     w_pull;
    logic                     w_load_new;
    logic                     w_pop_top;

    assign w_hit      = i_cmd.scan && r_tok && r_valid && (r_key == i_skey);
    assign w_pull     = w_hit || (i_cmd.shift && r_tok);
    assign w_load_new = i_cmd.push && !r_valid && i_below_valid;
    assign w_pop_top  = i_cmd.pop && r_valid && !i_above_valid;

    assign o_valid   = r_valid;
    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_hit     = w_hit;
    assign o_sel     = w_pop_top || w_hit;
    assign o_last    = w_pull && !i_above_valid;
    assign o_miss    = i_cmd.scan && r_tok && !r_valid;
    assign o_tok     = (i_cmd.scan && r_tok && r_valid && !w_hit)
                     || (w_pull && i_above_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (w_load_new) begin
                r_valid <= 1'b1;
            end else if (w_pop_top) begin
                r_valid <= 1'b0;
            end else if (w_pull) begin
                r_valid <= i_above_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_new) begin
            r_key     <= i_new_key;
            r_payload <= i_new_payload;
        end else if (w_pull && i_above_valid) begin
            r_key     <= i_above_key;
            r_payload <= i_above_payload;
        end
    end

endmodule

[rtl/keyed_stack_with_search_remove_core.sv]
`timescale 1ns / 1ps
// Push, pop and unknown operations complete from idle; their result is registered.
// Search: the token walks one cell per cycle to the match, then the records above it move
// down one cell per cycle until the top record has moved.
// A new transaction is taken once the previous one has handed its result to the output.
// Synchronous active-low reset empties the stack; stored records are not cleared.
module keyed_stack_with_search_remove_core #(
    parameter int DEPTH         = ksr_pkg::DEF_DEPTH,
    parameter int PAYLOAD_WIDTH = ksr_pkg::DEF_PAYLOAD_W,
    parameter int CW            = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_kind,
    input  logic [ksr_pkg::KEY_W-1:0]  i_key,
    input  logic [PAYLOAD_WIDTH-1:0]   i_payload,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [ksr_pkg::KEY_W-1:0]  o_out_key,
    output logic [PAYLOAD_WIDTH-1:0]   o_out_payload,
    output logic [CW-1:0]              o_count,
    output logic                       o_is_empty
);
    import ksr_pkg::*;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [KEY_W-1:0]         r_skey;
    logic [1:0]               r_res_status, n_res_status;
    logic [KEY_W-1:0]         r_res_key, n_res_key;
    logic [PAYLOAD_WIDTH-1:0] r_res_payload, n_res_payload;
    logic                     w_res_load;

    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic [KEY_W-1:0]         r_out_key;
    logic [PAYLOAD_WIDTH-1:0] r_out_payload;
    logic [CW-1:0]            r_out_count;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_slot_free;
    logic                     w_start;
    t_cmd                     w_cmd;

    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH-1:0]         w_tok_out;
    logic [DEPTH-1:0]         w_hit;
    logic [DEPTH-1:0]         w_sel;
    logic [DEPTH-1:0]         w_last;
    logic [DEPTH-1:0]         w_miss;
    logic [KEY_W-1:0]         w_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_payload [DEPTH];
    logic [KEY_W-1:0]         w_sel_key;
    logic [PAYLOAD_WIDTH-1:0] w_sel_payload;

    logic                     w_fin;
    logic [1:0]               w_fin_status;
    logic [KEY_W-1:0]         w_fin_key;
    logic [PAYLOAD_WIDTH-1:0] w_fin_payload;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_start     = w_accept && (i_kind == KIND_SEARCH);

    assign w_cmd.push  = w_accept && (i_kind == KIND_PUSH) && !w_full;
    assign w_cmd.pop   = w_accept && (i_kind == KIND_POP) && !w_empty;
    assign w_cmd.scan  = (r_state == S_SCAN);
    assign w_cmd.shift = (r_state == S_SHIFT);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     w_tok_in;
        logic                     w_below_valid;
        logic                     w_above_valid;
        logic [KEY_W-1:0]         w_above_key;
        logic [PAYLOAD_WIDTH-1:0] w_above_payload;

        if (g == 0) begin : g_bottom
            assign w_tok_in      = w_start;
            assign w_below_valid = 1'b1;
        end else begin : g_mid
            assign w_tok_in      = w_tok_out[g-1];
            assign w_below_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_top
            assign w_above_valid   = 1'b0;
            assign w_above_key     = '0;
            assign w_above_payload = '0;
        end else begin : g_below_top
            assign w_above_valid   = w_valid[g+1];
            assign w_above_key     = w_key[g+1];
            assign w_above_payload = w_payload[g+1];
        end

        ksr_cell #(
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (w_cmd),
            .i_new_key       (i_key),
            .i_new_payload   (i_payload),
            .i_skey          (r_skey),
            .i_tok           (w_tok_in),
            .i_below_valid   (w_below_valid),
            .i_above_valid   (w_above_valid),
            .i_above_key     (w_above_key),
            .i_above_payload (w_above_payload),
            .o_valid         (w_valid[g]),
            .o_key           (w_key[g]),
            .o_payload       (w_payload[g]),
            .o_tok           (w_tok_out[g]),
            .o_hit           (w_hit[g]),
            .o_sel           (w_sel[g]),
            .o_last          (w_last[g]),
            .o_miss          (w_miss[g])
        );
    end

    always_comb begin
        w_sel_key     = '0;
        w_sel_payload = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_key     = w_sel_key | (w_sel[i] ? w_key[i] : '0);
            w_sel_payload = w_sel_payload | (w_sel[i] ? w_payload[i] : '0);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        w_fin         = 1'b0;
        w_fin_status  = ST_OK;
        w_fin_key     = '0;
        w_fin_payload = '0;
        w_res_load    = 1'b0;
        n_res_status  = ST_OK;
        n_res_key     = w_sel_key;
        n_res_payload = w_sel_payload;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_PUSH: begin
                            w_fin = 1'b1;
                            if (w_full) begin
                                w_fin_status = ST_FULL;
                            end else begin
                                n_count = CW'(r_count + 1'b1);
                            end
                        end
                        KIND_POP: begin
                            w_fin = 1'b1;
                            if (w_empty) begin
                                w_fin_status = ST_EMPTY;
                            end else begin
                                n_count       = CW'(r_count - 1'b1);
                                w_fin_key     = w_sel_key;
                                w_fin_payload = w_sel_payload;
                            end
                        end
                        KIND_SEARCH: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (|w_hit) begin
                    n_count = CW'(r_count - 1'b1);
                    if (|w_last) begin
                        w_fin         = 1'b1;
                        w_fin_key     = w_sel_key;
                        w_fin_payload = w_sel_payload;
                    end else begin
                        w_res_load = 1'b1;
                        n_state    = S_SHIFT;
                    end
                end else if ((|w_miss) || w_tok_out[DEPTH-1]) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_NOT_FOUND;
                end
            end
            S_SHIFT: begin
                if (|w_last) begin
                    w_fin         = 1'b1;
                    w_fin_key     = r_res_key;
                    w_fin_payload = r_res_payload;
                end
            end
            S_POST: begin
                w_fin         = 1'b1;
                w_fin_status  = r_res_status;
                w_fin_key     = r_res_key;
                w_fin_payload = r_res_payload;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            if (w_slot_free) begin
                n_state = S_IDLE;
            end else begin
                n_state       = S_POST;
                w_res_load    = 1'b1;
                n_res_status  = w_fin_status;
                n_res_key     = w_fin_key;
                n_res_payload = w_fin_payload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fin && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_skey <= i_key;
        end
        if (w_res_load) begin
            r_res_status  <= n_res_status;
            r_res_key     <= n_res_key;
            r_res_payload <= n_res_payload;
        end
        if (w_fin && w_slot_free) begin
            r_out_status  <= w_fin_status;
            r_out_key     <= w_fin_key;
            r_out_payload <= w_fin_payload;
            r_out_count   <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_payload;
    assign o_count       = r_out_count;
    assign o_is_empty    = (r_out_count == '0);

    a_tok_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_out))
        else $error("search token passed by more than one cell");

    a_tok_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (|w_hit == 1'b0) && ($countones(w_last) <= 1))
        else $error("shift pass lost its token");

    // while shifting, the record just moved down is still held twice
    a_fill_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count) + ((r_state == S_SHIFT) ? 1 : 0))
        else $error("occupied cells disagree with fill count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FULL)) |-> (r_out_count == CW'(DEPTH)))
        else $error("full reported below capacity");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
    import ksr_pkg::*;

    localparam int DEPTH     = DEF_DEPTH;
    localparam int PAYLOAD_W = DEF_PAYLOAD_W;
    localparam int CW        = $clog2(DEPTH + 1);
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [1:0]           status;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [CW-1:0]        count;
        logic                 is_empty;
    } stack_result_t;

    class lifo_shadow;
        logic [KEY_W-1:0]     keys [DEPTH];
        logic [PAYLOAD_W-1:0] pays [DEPTH];
        int                   fill;
        stack_result_t        due_results [$];
        int                   errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("tb: mismatch at %0t: %s", $realtime, what);
            end
        endfunction

        function void note_op(logic [1:0] kind, logic [KEY_W-1:0] key,
                              logic [PAYLOAD_W-1:0] payload);
            stack_result_t r;
            int hit_at;
            r.status  = ST_OK;
            r.key     = '0;
            r.payload = '0;
            hit_at    = -1;
            case (kind)
                KIND_PUSH: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        keys[fill] = key;
                        pays[fill] = payload;
                        fill++;
                    end
                end
                KIND_POP: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        fill--;
                        r.key     = keys[fill];
                        r.payload = pays[fill];
                    end
                end
                KIND_SEARCH: begin
                    for (int i = 0; i < fill; i++) begin
                        if (hit_at < 0 && keys[i] == key) hit_at = i;
                    end
                    if (hit_at < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.key     = keys[hit_at];
                        r.payload = pays[hit_at];
                        for (int i = hit_at; i + 1 < fill; i++) begin
                            keys[i] = keys[i + 1];
                            pays[i] = pays[i + 1];
                        end
                        fill--;
                    end
                end
                default: ;
            endcase
            r.count    = fill[CW-1:0];
            r.is_empty = (fill == 0);
            due_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [KEY_W-1:0] key,
                                   logic [PAYLOAD_W-1:0] payload, logic [CW-1:0] count,
                                   logic is_empty);
            stack_result_t e;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, status %0d", status));
                return;
            end
            e = due_results.pop_front();
            if (status !== e.status)
                report_mismatch($sformatf("status %0d, want %0d", status, e.status));
            if (key !== e.key)
                report_mismatch($sformatf("key %h, want %h", key, e.key));
            if (payload !== e.payload)
                report_mismatch($sformatf("payload %h, want %h", payload, e.payload));
            if (count !== e.count)
                report_mismatch($sformatf("count %0d, want %0d", count, e.count));
            if (is_empty !== e.is_empty)
                report_mismatch($sformatf("is_empty %b, want %b", is_empty, e.is_empty));
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [1:0]           i_kind      = KIND_PUSH;
    logic [KEY_W-1:0]     i_key       = '0;
    logic [PAYLOAD_W-1:0] i_payload   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_status;
    logic [KEY_W-1:0]     o_out_key;
    logic [PAYLOAD_W-1:0] o_out_payload;
    logic [CW-1:0]        o_count;
    logic                 o_is_empty;

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    logic [KEY_W-1:0] key_pool [8];

    lifo_shadow sb = new();

    keyed_stack_with_search_remove_core #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_status, o_out_key, o_out_payload, o_count, o_is_empty);
        end
    end

    // receiver back-pressure, drawn afresh for each transaction
    initial begin
        int w;
        forever begin
            w = out_idle_on ? $urandom_range(0, 10) : 0;
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid && !i_out_stall));
        end
    end

    task automatic issue(logic [1:0] kind, logic [KEY_W-1:0] key,
                         logic [PAYLOAD_W-1:0] payload);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_payload  <= payload;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_op(kind, key, payload);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 55) return key_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic run_directed();
        logic [KEY_W-1:0] k;
        issue(KIND_POP, '1, '1);
        issue(KIND_SEARCH, '0, '0);
        issue(KIND_UNUSED, '1, '1);
        // fill to the brim, duplicate zero keys low in the stack
        for (int i = 0; i < DEPTH; i++) begin
            case (i)
                0, 2:    k = '0;
                1:       k = '1;
                3:       k = 64'h8000_0000_0000_0001;
                default: k = {$urandom, $urandom};
            endcase
            issue(KIND_PUSH, k, (i == 0) ? '1 : (i == 1) ? '0 : $urandom);
        end
        issue(KIND_PUSH, '1, '1);
        issue(KIND_UNUSED, '0, '0);
        issue(KIND_SEARCH, '0, '0);
        issue(KIND_SEARCH, '0, '1);
        issue(KIND_SEARCH, 64'h0123_4567_89ab_cdef, '0);
        issue(KIND_SEARCH, '1, '0);
        issue(KIND_POP, '0, '0);
    endtask

    task automatic run_random(int n);
        int done;
        int fill_bias;
        int r;
        int push_pct;
        logic [KEY_W-1:0] k;
        done      = 0;
        fill_bias = 1;
        while (done < n) begin
            if (done % 40 == 0) begin
                fill_bias   = $urandom_range(0, 2);
                r           = $urandom_range(0, 3);
                in_idle_on  = r[0];
                out_idle_on = r[1];
                key_pool[$urandom_range(2, 7)] = {$urandom, $urandom};
            end
            push_pct = (fill_bias == 2) ? 65 : (fill_bias == 1) ? 40 : 20;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                // answered with OK status and no stack change, not counted
                issue(KIND_UNUSED, {$urandom, $urandom}, $urandom);
            end else if (r < 2 + push_pct) begin
                issue(KIND_PUSH, pick_key(), pick_payload());
                done++;
            end else if (r < 2 + push_pct + (98 - push_pct) / 2) begin
                issue(KIND_POP, {$urandom, $urandom}, $urandom);
                done++;
            end else begin
                if (sb.fill > 0 && $urandom_range(0, 99) < 70)
                    k = sb.keys[$urandom_range(0, sb.fill - 1)];
                else
                    k = pick_key();
                issue(KIND_SEARCH, k, $urandom);
                done++;
            end
        end
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(1525);
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
